// ===== rtl/clnib_pkg.sv =====
package clnib_pkg;

   // Sequencer steps of the pin engine
   typedef enum logic [4:0] {
      STEP_IDLE  = 5'd0,
      STEP_PWR   = 5'd1,
      STEP_N3A   = 5'd2,
      STEP_W5    = 5'd3,
      STEP_N3B   = 5'd4,
      STEP_W150  = 5'd5,
      STEP_N3C   = 5'd6,
      STEP_N2    = 5'd7,
      STEP_CFG_H = 5'd8,
      STEP_CFG_L = 5'd9,
      STEP_DSP_H = 5'd10,
      STEP_DSP_L = 5'd11,
      STEP_CLR_H = 5'd12,
      STEP_CLR_L = 5'd13,
      STEP_CLR_W = 5'd14,
      STEP_ENT_H = 5'd15,
      STEP_ENT_L = 5'd16,
      STEP_REQ_H = 5'd17,
      STEP_REQ_L = 5'd18,
      STEP_REQ_W = 5'd19
   } step_type;

   typedef enum logic [2:0] {
      OP_CMD    = 3'd0,
      OP_CHAR   = 3'd1,
      OP_CURSOR = 3'd2,
      OP_CLEAR  = 3'd3,
      OP_HOME   = 3'd4,
      OP_INIT   = 3'd5
   } opcode_type;

   // Register indexes on the csr port
   localparam logic [2:0] REG_PULSE_HIGH = 3'd0;
   localparam logic [2:0] REG_POST_PULSE = 3'd1;
   localparam logic [2:0] REG_TICKS_MS   = 3'd2;
   localparam logic [2:0] REG_POWER_UP   = 3'd3;
   localparam logic [2:0] REG_CLEAR_WAIT = 3'd4;

   localparam logic [7:0]  ROW1_BASE    = 8'h80;
   localparam logic [7:0]  ROW2_BASE    = 8'hC0;
   localparam logic [3:0]  NIB_INIT3    = 4'h3;
   localparam logic [3:0]  NIB_INIT2    = 4'h2;
   localparam logic [7:0]  BYTE_FUNCSET = 8'h28;
   localparam logic [7:0]  BYTE_DISPON  = 8'h0E;
   localparam logic [7:0]  BYTE_CLEAR   = 8'h01;
   localparam logic [7:0]  BYTE_HOME    = 8'h02;
   localparam logic [7:0]  BYTE_ENTRY   = 8'h06;
   localparam logic [7:0]  WAIT_5_MS    = 8'd5;
   localparam logic [23:0] WAIT_150     = 24'd150;

   localparam logic [9:0]  RST_PULSE_HIGH = 10'd10;
   localparam logic [11:0] RST_POST_PULSE = 12'd100;
   localparam logic [15:0] RST_TICKS_MS   = 16'd1000;
   localparam logic [7:0]  RST_POWER_UP   = 8'd40;
   localparam logic [7:0]  RST_CLEAR_WAIT = 8'd2;

   typedef struct packed {
      logic [9:0]  pulse_high;
      logic [11:0] post_pulse;
      logic [15:0] ticks_ms;
      logic [7:0]  power_up_ms;
      logic [7:0]  clear_wait_ms;
   } cfg_type;

   typedef struct packed {
      step_type    step;
      logic [1:0]  phase;
      logic [23:0] timer;
      logic [7:0]  held_byte;
      logic        held_rs;
      logic [7:0]  after_ms;
      logic [5:0]  pins;       // 3:0 data, 4 EN, 5 RS
   } state_type;

   typedef struct packed {
      logic        refused;
      logic        accepted;
      logic        busy;
      logic [3:0]  nibble;
      logic        en;
      logic        rw;
      logic        rs;
   } result_type;

   typedef struct packed {
      logic        valid;
      opcode_type  opcode;
      logic [7:0]  byte_val;
      logic [1:0]  row;
      logic [6:0]  col;
   } request_type;

endpackage

// ===== rtl/char_lcd_nibble_interface.sv =====
// The result item for an input tick appears in the rsp register in the cycle after accept.
// Throughput: one item per clock while the result register is empty or drained; the sequencer
// step logic and its single 8x16 multiplier complete a tick between the state registers and the
// result register. Reset (synchronous, active high): sequencer idle, pins low, registers at their
// defaults, result register empty.
module char_lcd_nibble_interface
   import clnib_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request tick channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // req_byte[7:0], cursor_row[9:8], cursor_col[16:10], zero
   input  logic [3:0]  req_tuser,   // req_valid[0], opcode[3:1]
   // pin level result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // rs_pin[0], rw_pin[1], en_pin[2], data_nibble[6:3],
                                    // busy_res[7], accepted[8], refused[9], zero
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type     cfg;
   request_type req;
   state_type   state_ff;
   state_type   state_in;
   result_type  res;
   result_type  rsp_ff;
   logic        rsp_valid_ff;
   logic        accept;

   clnib_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Unpack the incoming tick
   assign req.valid    = req_tuser[0];
   assign req.opcode   = opcode_type'(req_tuser[3:1]);
   assign req.byte_val = req_tdata[7:0];
   assign req.row      = req_tdata[9:8];
   assign req.col      = req_tdata[16:10];

   clnib_step u_step (
      .cur (state_ff),
      .cfg (cfg),
      .req (req),
      .nxt (state_in),
      .res (res)
   );

   // Take a new tick whenever the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Hold the sequencer state; advance it only on an accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.step      <= STEP_IDLE;
         state_ff.phase     <= '0;
         state_ff.timer     <= '0;
         state_ff.held_byte <= '0;
         state_ff.held_rs   <= 1'b0;
         state_ff.after_ms  <= '0;
         state_ff.pins      <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   // Payload register needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.refused, rsp_ff.accepted, rsp_ff.busy, rsp_ff.nibble,
                        rsp_ff.en, rsp_ff.rw, rsp_ff.rs};

   // A tick is never both taken and refused
   a_acc_ref_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.accepted && rsp_ff.refused))
      else $error("accepted and refused both set");

   // An idle sequencer has no timer or phase left over
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff.step == STEP_IDLE) |-> (state_ff.timer == '0 && state_ff.phase == 2'd0))
      else $error("idle sequencer with live timer");

   // A running step always has ticks left
   a_busy_timer: assert property (@(posedge clock) disable iff (reset)
      (state_ff.step != STEP_IDLE) |-> (state_ff.timer != '0))
      else $error("running step with zero timer");

   // EN is high only during the pulse phase of a nibble
   a_en_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.pins[4] |-> (state_ff.phase == 2'd1))
      else $error("enable high outside pulse phase");

   // A refused tick leaves the sequencer busy
   a_refused_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.refused) |-> rsp_ff.busy)
      else $error("refused while not busy");

endmodule

// ===== rtl/clnib_csr.sv =====
module clnib_csr
   import clnib_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PULSE_HIGH: cfg_in.pulse_high    = csr_wdata[9:0];
            REG_POST_PULSE: cfg_in.post_pulse    = csr_wdata[11:0];
            REG_TICKS_MS:   cfg_in.ticks_ms      = csr_wdata;
            REG_POWER_UP:   cfg_in.power_up_ms   = csr_wdata[7:0];
            REG_CLEAR_WAIT: cfg_in.clear_wait_ms = csr_wdata[7:0];
            default: ; // unused indexes: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_high    <= RST_PULSE_HIGH;
         cfg_ff.post_pulse    <= RST_POST_PULSE;
         cfg_ff.ticks_ms      <= RST_TICKS_MS;
         cfg_ff.power_up_ms   <= RST_POWER_UP;
         cfg_ff.clear_wait_ms <= RST_CLEAR_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/clnib_step.sv =====
module clnib_step
   import clnib_pkg::*;
(
   input  state_type   cur,
   input  cfg_type     cfg,
   input  request_type req,
   output state_type   nxt,
   output result_type  res
);

   function automatic step_type next_step(step_type s);
      step_type n;
      n = STEP_IDLE;
      unique case (s) inside
         STEP_PWR, STEP_N3A, STEP_W5, STEP_N3B, STEP_W150, STEP_N3C, STEP_N2,
         STEP_CFG_H, STEP_CFG_L, STEP_DSP_H, STEP_DSP_L, STEP_CLR_H, STEP_CLR_L,
         STEP_CLR_W, STEP_ENT_H, STEP_REQ_H, STEP_REQ_L:
            n = step_type'(s + 5'd1);
         default: n = STEP_IDLE;
      endcase
      return n;
   endfunction

   // Milliseconds of a wait step; power-up by default
   function automatic logic [7:0] wait_ms(step_type s, logic [7:0] after_ms, cfg_type c);
      logic [7:0] m;
      m = c.power_up_ms;
      unique case (s) inside
         STEP_W5:               m = WAIT_5_MS;
         STEP_CLR_W, STEP_REQ_W: m = after_ms;
         default:               m = c.power_up_ms;
      endcase
      return m;
   endfunction

   // A millisecond wait of zero length is skipped
   function automatic logic wait_zero(step_type s, logic [7:0] after_ms, cfg_type c);
      logic z;
      z = 1'b0;
      unique case (s) inside
         STEP_PWR:               z = (c.power_up_ms == '0) || (c.ticks_ms == '0);
         STEP_W5:                z = (c.ticks_ms == '0);
         STEP_CLR_W, STEP_REQ_W: z = (after_ms == '0) || (c.ticks_ms == '0);
         default:                z = 1'b0;
      endcase
      return z;
   endfunction

   function automatic state_type enter_step(step_type s, state_type st, cfg_type c,
                                            logic [23:0] prod);
      state_type  n;
      step_type   s1;
      logic       drive;
      logic [3:0] nib;
      n     = st;
      drive = 1'b0;
      nib   = '0;
      s1    = s;
      if (wait_zero(s, st.after_ms, c)) begin
         s1 = next_step(s);
      end
      n.step  = s1;
      n.phase = 2'd0;
      unique case (s1) inside
         STEP_PWR, STEP_W5, STEP_CLR_W, STEP_REQ_W: n.timer = prod;
         STEP_W150: n.timer = WAIT_150;
         STEP_N3A, STEP_N3B, STEP_N3C: begin
            drive = 1'b1;
            nib   = NIB_INIT3;
         end
         STEP_N2: begin
            drive = 1'b1;
            nib   = NIB_INIT2;
         end
         STEP_CFG_H: begin
            n.held_byte = BYTE_FUNCSET;
            drive       = 1'b1;
            nib         = BYTE_FUNCSET[7:4];
         end
         STEP_DSP_H: begin
            n.held_byte = BYTE_DISPON;
            drive       = 1'b1;
            nib         = BYTE_DISPON[7:4];
         end
         STEP_CLR_H: begin
            n.held_byte = BYTE_CLEAR;
            drive       = 1'b1;
            nib         = BYTE_CLEAR[7:4];
         end
         STEP_ENT_H: begin
            n.held_byte = BYTE_ENTRY;
            drive       = 1'b1;
            nib         = BYTE_ENTRY[7:4];
         end
         STEP_REQ_H: begin
            drive = 1'b1;
            nib   = st.held_byte[7:4];
         end
         STEP_CFG_L, STEP_DSP_L, STEP_CLR_L, STEP_ENT_L, STEP_REQ_L: begin
            drive = 1'b1;
            nib   = st.held_byte[3:0];
         end
         default: begin
            n.step  = STEP_IDLE;
            n.timer = '0;
         end
      endcase
      if (drive) begin
         n.pins  = {st.held_rs, 1'b1, nib};
         n.phase = 2'd1;
         n.timer = (c.pulse_high == '0) ? 24'd1 : {14'b0, c.pulse_high};
      end
      return n;
   endfunction

   state_type   adv;
   state_type   pre;
   step_type    adv_target;
   logic        adv_enter;
   logic [23:0] dec;
   logic [7:0]  mul_ms;
   logic [23:0] prod;
   logic        acc;
   logic        refd;

   // Advance the running sequence by one tick
   always_comb begin
      adv        = cur;
      adv_enter  = 1'b0;
      adv_target = next_step(cur.step);
      dec        = cur.timer - 24'd1;
      if (cur.step != STEP_IDLE) begin
         if (dec != '0) begin
            adv.timer = dec;
         end else if (cur.phase == 2'd1) begin
            adv.phase   = 2'd2;
            adv.pins[4] = 1'b0;
            adv.timer   = (cfg.post_pulse == '0) ? 24'd1 : {12'b0, cfg.post_pulse};
         end else begin
            adv_enter = 1'b1;
         end
      end
   end

   // One shared multiplier: a wait that the advance path actually enters,
   // otherwise the power-up wait of a request taken in this tick
   assign mul_ms = (adv_enter && !wait_zero(adv_target, cur.after_ms, cfg)) ?
                   wait_ms(adv_target, cur.after_ms, cfg) : cfg.power_up_ms;
   assign prod   = {16'b0, mul_ms} * {8'b0, cfg.ticks_ms};

   always_comb begin
      pre  = adv_enter ? enter_step(adv_target, adv, cfg, prod) : adv;
      nxt  = pre;
      acc  = 1'b0;
      refd = 1'b0;
      if (req.valid) begin
         case (req.opcode) inside
            OP_CMD, OP_CHAR, OP_CURSOR, OP_CLEAR, OP_HOME, OP_INIT: begin
               if (pre.step != STEP_IDLE) begin
                  refd = 1'b1;
               end else begin
                  acc          = 1'b1;
                  nxt.held_rs  = 1'b0;
                  nxt.after_ms = '0;
                  case (req.opcode)
                     OP_CMD: begin
                        nxt.held_byte = req.byte_val;
                        nxt = enter_step(STEP_REQ_H, nxt, cfg, prod);
                     end
                     OP_CHAR: begin
                        nxt.held_rs   = 1'b1;
                        nxt.held_byte = req.byte_val;
                        nxt = enter_step(STEP_REQ_H, nxt, cfg, prod);
                     end
                     OP_CURSOR: begin
                        // rows other than one and two send nothing
                        if (req.row == 2'd1 || req.row == 2'd2) begin
                           nxt.held_byte = ({1'b0, req.col} - 8'd1) |
                                           ((req.row == 2'd1) ? ROW1_BASE : ROW2_BASE);
                           nxt = enter_step(STEP_REQ_H, nxt, cfg, prod);
                        end
                     end
                     OP_CLEAR: begin
                        nxt.held_byte = BYTE_CLEAR;
                        nxt.after_ms  = cfg.clear_wait_ms;
                        nxt = enter_step(STEP_REQ_H, nxt, cfg, prod);
                     end
                     OP_HOME: begin
                        nxt.held_byte = BYTE_HOME;
                        nxt.after_ms  = cfg.clear_wait_ms;
                        nxt = enter_step(STEP_REQ_H, nxt, cfg, prod);
                     end
                     default: begin
                        nxt.after_ms = cfg.clear_wait_ms;
                        nxt = enter_step(STEP_PWR, nxt, cfg, prod);
                     end
                  endcase
               end
            end
            default: ; // unknown opcodes: ignore
         endcase
      end
   end

   assign res.rs       = nxt.pins[5];
   assign res.rw       = 1'b0;
   assign res.en       = nxt.pins[4];
   assign res.nibble   = nxt.pins[3:0];
   assign res.busy     = (nxt.step != STEP_IDLE);
   assign res.accepted = acc;
   assign res.refused  = refd;

endmodule
